// ===== hdl/abtt_pkg.sv =====
`default_nettype none

package abtt_pkg;

  // default store depth and the result limit of one traversal
  localparam int CAPACITY_DEF = 64;
  localparam int MAX_OUT      = 64;
  localparam int OUT_CNT_W    = $clog2(MAX_OUT + 1);
  localparam int VALUE_W      = 32;

  typedef logic [OUT_CNT_W-1:0] out_cnt_t;
  typedef logic [VALUE_W-1:0]   value_t;

  localparam out_cnt_t OUT_LIMIT  = out_cnt_t'(MAX_OUT);
  // a stored -1 marks an absent node for the recursive orders
  localparam value_t   NODE_EMPTY = '1;

  typedef enum logic {
    OP_INSERT   = 1'b0,
    OP_TRAVERSE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ORD_IN    = 2'd0,
    ORD_PRE   = 2'd1,
    ORD_POST  = 2'd2,
    ORD_ARRAY = 2'd3
  } order_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_ITEM     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // progress of one node frame: before left, between children, after right
  typedef enum logic [1:0] {
    PH_DOWN = 2'd0,
    PH_MID  = 2'd1,
    PH_UP   = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARR_RD,
    S_ARR_EMIT,
    S_WALK,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/abtt_store.sv =====
`default_nettype none

module abtt_store #(
  parameter int DEPTH = abtt_pkg::CAPACITY_DEF,
  parameter int AW    = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  wire abtt_pkg::value_t     wr_data_i,
  input  wire logic                 rd_en_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output abtt_pkg::value_t          rd_data_o
);
  import abtt_pkg::*;

  value_t mem_q [DEPTH];
  value_t rd_data_q;

  // node values, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/array_binary_tree_traversal.sv =====
// Array-stored binary tree with ordered read-out.
// Input channel (in_valid_i / in_ready_o): one request carries operation_i,
// value_i and order_i. An insert appends value_i at the next free slot and
// gives one result (inserted, or full when all CAPACITY slots are used).
// A traverse gives the stored values in in-order, pre-order, post-order or
// array order, one result each, the final one flagged by last_o; a traversal
// that finds nothing gives a single empty-status result.
// Output channel (out_valid_o / out_ready_i) is fed from an output register.
// An insert's result is registered and is valid in the cycle after the insert
// is taken. A recursive traversal steps through each visited node in its phases
// before the left child, between the children and after the right child, and
// pops a node holding -1 without visiting it; array order reads each entry from
// node memory, then issues it. Results trail by one entry, since a value is held
// back until it is known whether another follows. At most 64 results per request.
// A new request is taken only after the previous one has issued its last
// result into the output register.
// Reset clears the node count, the walk state and the output valid flag; the
// node memory needs no clearing. When the receiver stalls, the walk holds
// in place as soon as the output register and the one-entry hold are full.
`default_nettype none

module array_binary_tree_traversal #(
  parameter int CAPACITY = abtt_pkg::CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [1:0]  order_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] node_value_o,
  output logic [1:0]       status_o,
  output logic             last_o
);
  import abtt_pkg::*;

  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CH_W        = IDX_W + 2;
  localparam int STACK_DEPTH = IDX_W;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SP_IDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   top_idx_q, top_idx_d;
  phase_e             top_ph_q, top_ph_d;
  value_t             top_val_q, top_val_d;
  logic [SP_W-1:0]    sp_q, sp_d;
  order_e             ord_q, ord_d;
  out_cnt_t           n_q, n_d;
  logic               pend_valid_q, pend_valid_d;
  value_t             pend_val_q, pend_val_d;
  logic               out_valid_q;
  value_t             out_val_q;
  status_e            out_st_q;
  logic               out_last_q;

  // saved parent frames
  logic [IDX_W-1:0]   stk_idx_q [STACK_DEPTH];
  phase_e             stk_ph_q  [STACK_DEPTH];
  value_t             stk_val_q [STACK_DEPTH];

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  value_t             rd_data;

  logic               out_free;
  logic               hold;
  logic               emit;
  value_t             emit_val;
  logic               push;
  logic               pop;
  phase_e             save_ph;
  value_t             save_val;
  logic [CH_W-1:0]    left_idx;
  logic [CH_W-1:0]    right_idx;
  logic [SP_W-1:0]    sp_dec;
  logic               out_load;
  value_t             out_val_n;
  status_e            out_st_n;
  logic               out_last_n;

  abtt_store #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (value_t'(value_i)),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_free  = !out_valid_q || out_ready_i;
  assign hold      = pend_valid_q && !out_free;
  assign left_idx  = {1'b0, top_idx_q, 1'b1};
  assign right_idx = {1'b0, top_idx_q, 1'b0} + CH_W'(2);
  assign sp_dec    = sp_q - 1'b1;

  // request sequencing, tree walk and result hand-over
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    top_idx_d    = top_idx_q;
    top_ph_d     = top_ph_q;
    top_val_d    = top_val_q;
    sp_d         = sp_q;
    ord_d        = ord_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_val_d   = pend_val_q;
    in_ready_o   = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = count_q[IDX_W-1:0];
    rd_en        = 1'b0;
    rd_addr      = top_idx_q;
    emit         = 1'b0;
    emit_val     = top_val_q;
    push         = 1'b0;
    pop          = 1'b0;
    save_ph      = top_ph_q;
    save_val     = top_val_q;
    out_load     = 1'b0;
    out_val_n    = '0;
    out_st_n     = ST_EMPTY;
    out_last_n   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          n_d = '0;
          if (op_e'(operation_i) == OP_INSERT) begin
            out_load = 1'b1;
            if (count_q < CNT_W'(CAPACITY)) begin
              wr_en    = 1'b1;
              count_d  = count_q + 1'b1;
              out_st_n = ST_INSERTED;
            end else begin
              out_st_n = ST_FULL;
            end
          end else begin
            ord_d     = order_e'(order_i);
            top_idx_d = '0;
            top_ph_d  = PH_DOWN;
            sp_d      = '0;
            if (count_q == '0) begin
              state_d = S_FINISH;
            end else if (order_e'(order_i) == ORD_ARRAY) begin
              state_d = S_ARR_RD;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = S_WALK;
            end
          end
        end
      end

      S_ARR_RD: begin
        rd_en   = 1'b1;
        state_d = S_ARR_EMIT;
      end

      S_ARR_EMIT: begin
        if (!hold) begin
          emit     = 1'b1;
          emit_val = rd_data;
          if ((CNT_W'(top_idx_q) + 1'b1) == count_q || (n_q + 1'b1) == OUT_LIMIT) begin
            state_d = S_FINISH;
          end else begin
            top_idx_d = top_idx_q + 1'b1;
            state_d   = S_ARR_RD;
          end
        end
      end

      S_WALK: begin
        if (!hold) begin
          unique case (top_ph_q)
            PH_DOWN: begin
              if (rd_data == NODE_EMPTY) begin
                pop = 1'b1;
              end else begin
                emit      = (ord_q == ORD_PRE);
                emit_val  = rd_data;
                top_val_d = rd_data;
                top_ph_d  = PH_MID;
                save_ph   = PH_MID;
                save_val  = rd_data;
                if (left_idx < CH_W'(count_q)) begin
                  push    = 1'b1;
                  rd_addr = left_idx[IDX_W-1:0];
                end
              end
            end
            PH_MID: begin
              emit     = (ord_q == ORD_IN);
              top_ph_d = PH_UP;
              save_ph  = PH_UP;
              if (right_idx < CH_W'(count_q)) begin
                push    = 1'b1;
                rd_addr = right_idx[IDX_W-1:0];
              end
            end
            PH_UP: begin
              emit = (ord_q == ORD_POST);
              pop  = 1'b1;
            end
            default: begin
              pop = 1'b1;
            end
          endcase

          // descend: park the current frame, the child read is in flight
          if (push) begin
            rd_en     = 1'b1;
            sp_d      = sp_q + 1'b1;
            top_idx_d = rd_addr;
            top_ph_d  = PH_DOWN;
          end

          // ascend: the parent frame becomes the top again
          if (pop) begin
            if (sp_q == '0) begin
              state_d = S_FINISH;
            end else begin
              sp_d      = sp_dec;
              top_idx_d = stk_idx_q[sp_dec[SP_IDX_W-1:0]];
              top_ph_d  = stk_ph_q[sp_dec[SP_IDX_W-1:0]];
              top_val_d = stk_val_q[sp_dec[SP_IDX_W-1:0]];
            end
          end

          if (emit && (n_q + 1'b1) == OUT_LIMIT) begin
            state_d = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_n   = 1'b1;
          pend_valid_d = 1'b0;
          if (pend_valid_q) begin
            out_val_n = pend_val_q;
            out_st_n  = ST_ITEM;
          end else begin
            out_st_n = ST_EMPTY;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a new value pushes the held one out; the final one waits for the close
    if (emit) begin
      if (pend_valid_q) begin
        out_load   = 1'b1;
        out_val_n  = pend_val_q;
        out_st_n   = ST_ITEM;
        out_last_n = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_val_d   = emit_val;
      n_d          = n_q + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      sp_q         <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      sp_q         <= sp_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk frame, held value and output payload
  always_ff @(posedge clk_i) begin
    top_idx_q  <= top_idx_d;
    top_ph_q   <= top_ph_d;
    top_val_q  <= top_val_d;
    ord_q      <= ord_d;
    pend_val_q <= pend_val_d;
    if (out_load) begin
      out_val_q  <= out_val_n;
      out_st_q   <= out_st_n;
      out_last_q <= out_last_n;
    end
    if (push) begin
      stk_idx_q[sp_q[SP_IDX_W-1:0]] <= top_idx_q;
      stk_ph_q[sp_q[SP_IDX_W-1:0]]  <= save_ph;
      stk_val_q[sp_q[SP_IDX_W-1:0]] <= save_val;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_value_o = out_val_q;
  assign status_o     = out_st_q;
  assign last_o       = out_last_q;

`ifndef NO_ASSERTIONS
  // the frame stack never runs past the tree height
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("frame stack overflow");

  // the store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("node count beyond capacity");

  // no value is left held back when a new request may enter
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_valid_q)
    else $error("held value left over at idle");

  // only traversal items carry a node value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_ITEM) |-> node_value_o == '0)
    else $error("status result with nonzero value");

  // the result count of one request stays within the limit
  a_out_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= OUT_LIMIT)
    else $error("result limit exceeded");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import abtt_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 200;

  typedef struct packed {
    op_e    op;
    value_t value;
    order_e order;
  } request_t;

  typedef struct packed {
    value_t  node_value;
    status_e status;
    logic    last;
  } result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic              operation_i = 1'b0;
  logic signed [31:0] value_i    = '0;
  logic [1:0]        order_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic signed [31:0] node_value_o;
  logic [1:0]        status_o;
  logic              last_o;

  // tree shadow and expected results
  value_t   tree_mem [CAP];
  int       tree_count;
  value_t   visit_q[$];
  result_t  expected_q[$];
  request_t pending_q[$];
  request_t cur_req;
  result_t  exp_r;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors        = 0;
  int cycle_cnt     = 0;
  int n_insert      = 0;
  int n_full        = 0;
  int n_checked     = 0;
  int n_walk [4];
  int queued_inserts;

  array_binary_tree_traversal dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .order_i      (order_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .node_value_o (node_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always #2 clk_i = ~clk_i;

  // recursive walk, a -1 node hides itself and its subtree
  function automatic void walk_subtree(int unsigned idx, order_e ord);
    if (idx >= tree_count || tree_mem[idx] == NODE_EMPTY) return;
    if (ord == ORD_PRE) visit_q.push_back(tree_mem[idx]);
    walk_subtree(2 * idx + 1, ord);
    if (ord == ORD_IN) visit_q.push_back(tree_mem[idx]);
    walk_subtree(2 * idx + 2, ord);
    if (ord == ORD_POST) visit_q.push_back(tree_mem[idx]);
  endfunction

  // expected results of one accepted request
  function automatic void predict_request(request_t rq);
    result_t r;
    int      n;
    visit_q.delete();
    r.node_value = '0;
    r.last       = 1'b1;
    if (rq.op == OP_INSERT) begin
      if (tree_count < CAP) begin
        tree_mem[tree_count] = rq.value;
        tree_count++;
        r.status = ST_INSERTED;
        n_insert++;
      end else begin
        r.status = ST_FULL;
        n_full++;
      end
      expected_q.push_back(r);
      return;
    end
    n_walk[rq.order]++;
    if (rq.order == ORD_ARRAY) begin
      for (int i = 0; i < tree_count; i++) visit_q.push_back(tree_mem[i]);
    end else begin
      walk_subtree(0, rq.order);
    end
    n = (visit_q.size() > MAX_OUT) ? MAX_OUT : visit_q.size();
    if (n == 0) begin
      r.status = ST_EMPTY;
      expected_q.push_back(r);
      return;
    end
    for (int i = 0; i < n; i++) begin
      r.node_value = visit_q[i];
      r.status     = ST_ITEM;
      r.last       = (i == n - 1);
      expected_q.push_back(r);
    end
  endfunction

  // random request, node values lean towards -1 and the extremes
  function automatic request_t make_request(int insert_pct);
    request_t rq;
    int       pick;
    rq.op    = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_TRAVERSE;
    rq.order = order_e'($urandom_range(3));
    pick     = $urandom_range(99);
    if (pick < 12) rq.value = NODE_EMPTY;
    else if (pick < 15) rq.value = 32'h8000_0000;
    else if (pick < 18) rq.value = 32'h7fff_ffff;
    else if (pick < 20) rq.value = 32'hffff_fffe;
    else if (pick < 22) rq.value = '0;
    else rq.value = $urandom;
    return rq;
  endfunction

  function automatic request_t fixed_request(op_e op, value_t v, order_e ord);
    request_t rq;
    rq.op    = op;
    rq.value = v;
    rq.order = ord;
    return rq;
  endfunction

  // hold the stimulus until everything sent has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= 1'b0;
      value_i     <= '0;
      order_i     <= '0;
    end else begin
      if (in_valid_i && in_ready_o) predict_request(cur_req);
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req     = pending_q.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= cur_req.op;
          value_i     <= cur_req.value;
          order_i     <= cur_req.order;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: value %0d status %0d last %0b",
                   $time, node_value_o, status_o, last_o);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          n_checked++;
          if (node_value_o !== exp_r.node_value || status_o !== exp_r.status ||
              last_o !== exp_r.last) begin
            $display("%0t: mismatch: expected value %0d status %0d last %0b,",
                     $time, $signed(exp_r.node_value), exp_r.status, exp_r.last,
                     " got value %0d status %0d last %0b",
                     node_value_o, status_o, last_o);
            errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    tree_count     = 0;
    queued_inserts = 0;
    foreach (n_walk[i]) n_walk[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty store, extremes, -1 below the root
    send_idle_pct = 12;
    recv_idle_pct = 87;
    for (int i = 0; i < 4; i++)
      pending_q.push_back(fixed_request(OP_TRAVERSE, $urandom, order_e'(i)));
    pending_q.push_back(fixed_request(OP_INSERT, 32'h7fff_ffff, ORD_IN));
    pending_q.push_back(fixed_request(OP_INSERT, 32'h8000_0000, ORD_ARRAY));
    pending_q.push_back(fixed_request(OP_INSERT, NODE_EMPTY, ORD_PRE));
    pending_q.push_back(fixed_request(OP_INSERT, 32'h0000_0000, ORD_POST));
    pending_q.push_back(fixed_request(OP_INSERT, 32'hffff_fffe, ORD_IN));
    pending_q.push_back(fixed_request(OP_INSERT, NODE_EMPTY, ORD_IN));
    for (int i = 0; i < 4; i++)
      pending_q.push_back(fixed_request(OP_TRAVERSE, ~value_t'(i), order_e'(i)));
    pending_q.push_back(fixed_request(OP_INSERT, 32'h0000_0001, ORD_IN));
    pending_q.push_back(fixed_request(OP_INSERT, 32'h5555_5555, ORD_IN));
    pending_q.push_back(fixed_request(OP_INSERT, 32'haaaa_aaaa, ORD_IN));
    for (int i = 0; i < 4; i++)
      pending_q.push_back(fixed_request(OP_TRAVERSE, 32'h0, order_e'(i)));
    queued_inserts = 9;
    wait_drained();

    // random, slow receiver
    for (int i = 0; i < 50; i++) begin
      pending_q.push_back(make_request(55));
      if (pending_q[$].op == OP_INSERT) queued_inserts++;
    end
    wait_drained();

    // random, slow sender
    send_idle_pct = 87;
    recv_idle_pct = 12;
    for (int i = 0; i < 50; i++) begin
      pending_q.push_back(make_request(55));
      if (pending_q[$].op == OP_INSERT) queued_inserts++;
    end
    wait_drained();

    // random at full rate, then top the store up past full
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 35; i++) begin
      pending_q.push_back(make_request(55));
      if (pending_q[$].op == OP_INSERT) queued_inserts++;
    end
    while (queued_inserts < CAP + 3) begin
      pending_q.push_back(make_request(100));
      queued_inserts++;
    end
    for (int i = 0; i < 4; i++)
      pending_q.push_back(fixed_request(OP_TRAVERSE, $urandom, order_e'(i)));
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("inserts %0d, rejected as full %0d, walks in/pre/post/array %0d/%0d/%0d/%0d",
             n_insert, n_full, n_walk[ORD_IN], n_walk[ORD_PRE], n_walk[ORD_POST],
             n_walk[ORD_ARRAY]);
    $display("%0d results compared, %0d errors, %0d cycles", n_checked, errors, cycle_cnt);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
